FILE: rtl/core/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

   localparam int PIX_W       = 8;
   localparam int COUNT_W     = 20;
   localparam int SUM_W       = 28;
   localparam int VOTE_W      = 8;
   localparam int CSR_DATA_W  = 20;
   localparam int CSR_INDEX_W = 3;

   localparam int MAX_FRAME_PIXELS = 524288;
   localparam int COUNT_LIMIT      = (1 << COUNT_W) - 1;
   localparam int FRAME_CAP_INT    =
      (MAX_FRAME_PIXELS > COUNT_LIMIT) ? COUNT_LIMIT : MAX_FRAME_PIXELS;
   localparam logic [COUNT_W-1:0] FRAME_CAP = COUNT_W'(FRAME_CAP_INT);

   localparam logic [PIX_W-1:0]   PIXEL_THRESHOLD_RST = PIX_W'(110);
   localparam logic [PIX_W-1:0]   MEAN_THRESHOLD_RST  = PIX_W'(110);
   localparam logic [COUNT_W-1:0] BRIGHT_NEEDED_RST   = COUNT_W'(153600);
   localparam logic [VOTE_W-1:0]  LOW_LIMIT_RST       = VOTE_W'(0);
   localparam logic [VOTE_W-1:0]  HIGH_LIMIT_RST      = VOTE_W'(50);
   localparam logic [VOTE_W-1:0]  RELOAD_VALUE_RST    = VOTE_W'(20);
   localparam logic [VOTE_W-1:0]  VOTE_RST            = VOTE_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_THRESHOLD = 3'd0,
      CSR_MEAN_THRESHOLD  = 3'd1,
      CSR_BRIGHT_NEEDED   = 3'd2,
      CSR_LOW_LIMIT       = 3'd3,
      CSR_HIGH_LIMIT      = 3'd4,
      CSR_RELOAD_VALUE    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      SCENE_UNKNOWN = 2'd0,
      SCENE_DARK    = 2'd1,
      SCENE_LIGHT   = 2'd2
   } scene_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_threshold;
      logic [PIX_W-1:0]   mean_threshold;
      logic [COUNT_W-1:0] bright_needed;
      logic [VOTE_W-1:0]  low_limit;
      logic [VOTE_W-1:0]  high_limit;
      logic [VOTE_W-1:0]  reload_value;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   sum;
      logic [COUNT_W-1:0] bright;
   } frame_total_type;

endpackage

`default_nettype wire

FILE: rtl/core/fbc_csr.sv
`default_nettype none

module fbc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [fbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fbc_pkg::CSR_DATA_W-1:0]    csr_wr_data,
   output fbc_pkg::cfg_type                       cfg
);

   fbc_pkg::cfg_type cfg_ff;
   fbc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (fbc_pkg::csr_index_type'(csr_index))
            fbc_pkg::CSR_PIXEL_THRESHOLD: begin
               cfg_in.pixel_threshold = csr_wr_data[fbc_pkg::PIX_W-1:0];
            end
            fbc_pkg::CSR_MEAN_THRESHOLD: begin
               cfg_in.mean_threshold = csr_wr_data[fbc_pkg::PIX_W-1:0];
            end
            fbc_pkg::CSR_BRIGHT_NEEDED: begin
               cfg_in.bright_needed = csr_wr_data[fbc_pkg::COUNT_W-1:0];
            end
            fbc_pkg::CSR_LOW_LIMIT: begin
               cfg_in.low_limit = csr_wr_data[fbc_pkg::VOTE_W-1:0];
            end
            fbc_pkg::CSR_HIGH_LIMIT: begin
               cfg_in.high_limit = csr_wr_data[fbc_pkg::VOTE_W-1:0];
            end
            fbc_pkg::CSR_RELOAD_VALUE: begin
               cfg_in.reload_value = csr_wr_data[fbc_pkg::VOTE_W-1:0];
            end
            default: begin
               // unmapped index: drop the write
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_threshold <= fbc_pkg::PIXEL_THRESHOLD_RST;
         cfg_ff.mean_threshold  <= fbc_pkg::MEAN_THRESHOLD_RST;
         cfg_ff.bright_needed   <= fbc_pkg::BRIGHT_NEEDED_RST;
         cfg_ff.low_limit       <= fbc_pkg::LOW_LIMIT_RST;
         cfg_ff.high_limit      <= fbc_pkg::HIGH_LIMIT_RST;
         cfg_ff.reload_value    <= fbc_pkg::RELOAD_VALUE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fbc_accum.sv
`default_nettype none

module fbc_accum (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output wire logic                          req_ready,
   input  wire logic [fbc_pkg::PIX_W-1:0]     req_pixel,
   input  wire logic                          req_frame_end,
   input  wire logic [fbc_pkg::PIX_W-1:0]     pixel_threshold,
   input  wire logic                          total_ready,
   output wire logic                          total_valid,
   output fbc_pkg::frame_total_type           total
);

   logic                        in_valid_ff;
   logic                        in_valid_in;
   logic [fbc_pkg::PIX_W-1:0]   in_pixel_ff;
   logic                        in_last_ff;

   logic [fbc_pkg::COUNT_W-1:0] count_ff;
   logic [fbc_pkg::COUNT_W-1:0] count_in;
   logic [fbc_pkg::SUM_W-1:0]   sum_ff;
   logic [fbc_pkg::SUM_W-1:0]   sum_in;
   logic [fbc_pkg::COUNT_W-1:0] bright_ff;
   logic [fbc_pkg::COUNT_W-1:0] bright_in;

   logic                        tot_valid_ff;
   logic                        tot_valid_in;
   fbc_pkg::frame_total_type    tot_ff;
   fbc_pkg::frame_total_type    tot_in;

   fbc_pkg::frame_total_type    upd;
   logic                        below_cap;
   logic                        tot_free;
   logic                        in_go;
   logic                        in_take;

   assign tot_free  = !tot_valid_ff || total_ready;
   // a pixel that does not end a frame never waits on the stage below
   assign in_go     = in_valid_ff && (!in_last_ff || tot_free);
   assign req_ready = !in_valid_ff || in_go;
   assign in_take   = req_valid && req_ready;

   assign below_cap = count_ff < fbc_pkg::FRAME_CAP;

   always_comb begin
      upd.count  = count_ff;
      upd.sum    = sum_ff;
      upd.bright = bright_ff;
      if (below_cap) begin
         upd.count = count_ff + fbc_pkg::COUNT_W'(1);
         upd.sum   = sum_ff + fbc_pkg::SUM_W'(in_pixel_ff);
         if (in_pixel_ff > pixel_threshold) begin
            upd.bright = bright_ff + fbc_pkg::COUNT_W'(1);
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_take) begin
         in_valid_in = 1'b1;
      end else if (in_go) begin
         in_valid_in = 1'b0;
      end

      count_in  = count_ff;
      sum_in    = sum_ff;
      bright_in = bright_ff;
      if (in_go) begin
         if (in_last_ff) begin
            count_in  = '0;
            sum_in    = '0;
            bright_in = '0;
         end else begin
            count_in  = upd.count;
            sum_in    = upd.sum;
            bright_in = upd.bright;
         end
      end

      tot_valid_in = tot_valid_ff;
      tot_in       = tot_ff;
      if (in_go && in_last_ff) begin
         tot_valid_in = 1'b1;
         tot_in       = upd;
      end else if (total_ready) begin
         tot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         count_ff     <= '0;
         sum_ff       <= '0;
         bright_ff    <= '0;
         tot_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         bright_ff    <= bright_in;
         tot_valid_ff <= tot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_pixel_ff <= req_pixel;
         in_last_ff  <= req_frame_end;
      end
      tot_ff <= tot_in;
   end

   assign total_valid = tot_valid_ff;
   assign total       = tot_ff;

endmodule

`default_nettype wire

FILE: rtl/core/fbc_vote.sv
`default_nettype none

module fbc_vote (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fbc_pkg::cfg_type              cfg,
   input  wire logic                          total_valid,
   output wire logic                          total_ready,
   input  wire fbc_pkg::frame_total_type      total,
   output wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output wire logic [1:0]                    rsp_scene,
   output wire logic                          rsp_frame_dark,
   output wire logic [fbc_pkg::VOTE_W-1:0]    rsp_vote_level
);

   logic                         cmp_valid_ff;
   logic                         cmp_valid_in;
   logic [fbc_pkg::SUM_W-1:0]    cmp_prod_ff;
   logic [fbc_pkg::SUM_W-1:0]    cmp_sum_ff;
   logic                         cmp_few_ff;

   logic [fbc_pkg::VOTE_W-1:0]   vote_ff;
   logic [fbc_pkg::VOTE_W-1:0]   vote_in;
   fbc_pkg::scene_type           scene_ff;
   fbc_pkg::scene_type           scene_in;

   logic                         out_valid_ff;
   logic                         out_valid_in;
   logic                         out_dark_ff;

   logic                         out_free;
   logic                         cmp_free;
   logic                         cmp_take;
   logic                         cmp_go;
   logic                         dark;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign cmp_free    = !cmp_valid_ff || out_free;
   assign total_ready = cmp_free;
   assign cmp_take    = total_valid && cmp_free;
   assign cmp_go      = cmp_valid_ff && out_free;

   // exact mean test: sum <= threshold * count
   assign dark = (cmp_sum_ff <= cmp_prod_ff) || cmp_few_ff;

   always_comb begin
      cmp_valid_in = cmp_valid_ff;
      if (cmp_take) begin
         cmp_valid_in = 1'b1;
      end else if (out_free) begin
         cmp_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (cmp_go) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end

      vote_in  = vote_ff;
      scene_in = scene_ff;
      if (cmp_go) begin
         if (dark) begin
            if (vote_ff <= cfg.low_limit) begin
               scene_in = fbc_pkg::SCENE_DARK;
               vote_in  = cfg.reload_value;
            end else begin
               vote_in = vote_ff - fbc_pkg::VOTE_W'(1);
            end
         end else begin
            if (vote_ff >= cfg.high_limit) begin
               scene_in = fbc_pkg::SCENE_LIGHT;
               vote_in  = cfg.reload_value;
            end else begin
               vote_in = vote_ff + fbc_pkg::VOTE_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         vote_ff      <= fbc_pkg::VOTE_RST;
         scene_ff     <= fbc_pkg::SCENE_UNKNOWN;
      end else begin
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
         vote_ff      <= vote_in;
         scene_ff     <= scene_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_take) begin
         cmp_prod_ff <= fbc_pkg::SUM_W'(cfg.mean_threshold) * fbc_pkg::SUM_W'(total.count);
         cmp_sum_ff  <= total.sum;
         cmp_few_ff  <= total.bright < cfg.bright_needed;
      end
      if (cmp_go) begin
         out_dark_ff <= dark;
      end
   end

   // scene and vote registers double as the result payload
   assign rsp_valid      = out_valid_ff;
   assign rsp_scene      = scene_ff;
   assign rsp_frame_dark = out_dark_ff;
   assign rsp_vote_level = vote_ff;

endmodule

`default_nettype wire

FILE: rtl/core/frame_brightness_classifier_unit.sv
`default_nettype none

// Frame brightness classifier. Grey pixels stream in one per cycle on req_, the
// last pixel of a frame flagged by req_frame_end. Each pixel updates the frame's
// pixel count, pixel sum and bright count (counts stop at the frame cap); on the
// last pixel the totals move down a pipeline that forms threshold*count, votes
// the frame dark or light, steps the shared vote counter and switches the scene
// at its limits. One result per frame appears on rsp_ after the last pixel passes
// the input, total, compare and output registers. The accumulator adders set the
// rate of one pixel per cycle; a stalled result holds back the input only once
// the pipeline behind it has filled. Write csr_ registers only while the block
// is idle: pixel_threshold is applied as pixels enter, the rest at frame end.
module frame_brightness_classifier_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output wire logic                              req_ready,
   input  wire logic [fbc_pkg::PIX_W-1:0]         req_pixel,
   input  wire logic                              req_frame_end,
   output wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   output wire logic [1:0]                        rsp_scene,
   output wire logic                              rsp_frame_dark,
   output wire logic [fbc_pkg::VOTE_W-1:0]        rsp_vote_level,
   input  wire logic                              csr_wr_en,
   input  wire logic [fbc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fbc_pkg::CSR_DATA_W-1:0]    csr_wr_data
);

   fbc_pkg::cfg_type          cfg;
   fbc_pkg::frame_total_type  tot;
   logic                      tot_valid;
   logic                      tot_ready;

   fbc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   fbc_accum u_accum (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel       (req_pixel),
      .req_frame_end   (req_frame_end),
      .pixel_threshold (cfg.pixel_threshold),
      .total_ready     (tot_ready),
      .total_valid     (tot_valid),
      .total           (tot)
   );

   fbc_vote u_vote (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .total_valid    (tot_valid),
      .total_ready    (tot_ready),
      .total          (tot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scene      (rsp_scene),
      .rsp_frame_dark (rsp_frame_dark),
      .rsp_vote_level (rsp_vote_level)
   );

   // every finished frame holds at least one counted pixel
   a_total_nonempty: assert property (@(posedge clock) disable iff (reset)
      tot_valid |-> (tot.count != '0))
      else $error("frame total with zero pixels");

   a_bright_le_count: assert property (@(posedge clock) disable iff (reset)
      tot_valid |-> (tot.bright <= tot.count))
      else $error("bright count exceeds pixel count");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      tot_valid |-> (tot.sum < (fbc_pkg::SUM_W'(tot.count) << fbc_pkg::PIX_W)))
      else $error("pixel sum exceeds count times full scale");

   a_cap_held: assert property (@(posedge clock) disable iff (reset)
      tot_valid |-> (tot.count <= fbc_pkg::FRAME_CAP))
      else $error("pixel count passed the frame cap");

endmodule

`default_nettype wire
